// ===== rtl/ufd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_pkg
// Types and constants shared by the form-URL value decoder.
// ----------------------------------------------------------------------------
package ufd_pkg;

    // Character codes the decoder reacts to
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_LOW_MASK = 8'h07;

    // Buffer length after reset
    localparam logic [15:0] BUFFER_LEN_RESET = 16'd256;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_PLAIN = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_QUOTE = 3'd4,
        PH_AFTQ  = 3'd5,
        PH_DRAIN = 3'd6
    } ufd_phase_t;

    typedef enum logic [1:0] {
        END_AMP   = 2'd0,
        END_EQ    = 2'd1,
        END_EOS   = 2'd2,
        END_LIMIT = 2'd3
    } ufd_reason_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } ufd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] end_reason;
    } ufd_out_t;

    typedef struct packed {
        ufd_phase_t  phase;
        logic [3:0]  high_digit;
        logic [15:0] unit_count;
    } ufd_state_t;

    // Value of one escape digit, as the decoder defines it (no range check)
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UPA) begin
            v = (c & DIGIT_LOW_MASK) + 8'd9;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage

// ===== rtl/ufd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_step
// Decode step for one character: next decoder state and the result it gives.
// ----------------------------------------------------------------------------
module ufd_step (
    input  ufd_pkg::ufd_state_t cur_state,
    input  ufd_pkg::ufd_in_t    item,
    input  logic [15:0]         limit,
    output ufd_pkg::ufd_state_t nxt_state,
    output ufd_pkg::ufd_out_t   result,
    output logic                has_result
);
    import ufd_pkg::*;

    logic       at_limit;
    logic       was_drain;
    logic       do_plain;
    logic [7:0] ch;
    logic [7:0] dv;

    assign ch        = item.ch;
    assign dv        = digit_value(item.ch);
    assign at_limit  = cur_state.unit_count >= limit;
    assign was_drain = cur_state.phase == PH_DRAIN;

    always_comb begin
        nxt_state = cur_state;
        result    = '0;
        do_plain  = 1'b0;

        // Per-phase handling
        unique case (cur_state.phase)
            PH_PLAIN: begin
                do_plain = 1'b1;
            end
            PH_HEX1: begin
                nxt_state.high_digit = dv[3:0];
                nxt_state.phase      = PH_HEX2;
            end
            PH_HEX2: begin
                result.out_byte   = {cur_state.high_digit, 4'b0000} + dv;
                result.byte_valid = 1'b1;
                nxt_state.phase   = PH_PLAIN;
            end
            PH_QUOTE: begin
                if (ch == CH_QUOTE) begin
                    nxt_state.phase = PH_AFTQ;
                end else if (at_limit) begin
                    result.done_res   = 1'b1;
                    result.end_reason = END_LIMIT;
                    nxt_state.phase   = PH_DRAIN;
                end else begin
                    result.out_byte      = ch;
                    result.byte_valid    = 1'b1;
                    nxt_state.unit_count = cur_state.unit_count + 16'd1;
                end
            end
            PH_AFTQ: begin
                if (ch == CH_AMP) begin
                    result.done_res   = 1'b1;
                    result.end_reason = END_AMP;
                end else if (ch == CH_EQ) begin
                    result.done_res   = 1'b1;
                    result.end_reason = END_EQ;
                end
            end
            PH_DRAIN: begin
                if (ch == CH_AMP || ch == CH_EQ) begin
                    nxt_state.phase      = PH_SKIP;
                    nxt_state.unit_count = '0;
                    nxt_state.high_digit = '0;
                end
            end
            default: begin
                // Leading skip, also the unused phase code
                if (ch == CH_SPACE || ch == CH_EQ) begin
                    nxt_state.phase = PH_SKIP;
                end else if (ch == CH_QUOTE) begin
                    nxt_state.phase = PH_QUOTE;
                end else begin
                    do_plain = 1'b1;
                end
            end
        endcase

        // Plain decoding of one character
        if (do_plain) begin
            if (ch == CH_AMP) begin
                result.done_res   = 1'b1;
                result.end_reason = END_AMP;
            end else if (ch == CH_EQ) begin
                result.done_res   = 1'b1;
                result.end_reason = END_EQ;
            end else if (at_limit) begin
                result.done_res   = 1'b1;
                result.end_reason = END_LIMIT;
                nxt_state.phase   = PH_DRAIN;
            end else begin
                nxt_state.unit_count = cur_state.unit_count + 16'd1;
                nxt_state.phase      = PH_PLAIN;
                if (ch == CH_PLUS) begin
                    result.out_byte   = CH_SPACE;
                    result.byte_valid = 1'b1;
                end else if (ch == CH_PCT) begin
                    nxt_state.phase = PH_HEX1;
                end else if (ch != CH_SPACE) begin
                    result.out_byte   = ch;
                    result.byte_valid = 1'b1;
                end
            end
        end

        // A terminator ends the value; the length limit leaves it draining
        if (result.done_res && result.end_reason != END_LIMIT) begin
            nxt_state.phase      = PH_SKIP;
            nxt_state.unit_count = '0;
            nxt_state.high_digit = '0;
        end

        // End of string closes whatever is open
        if (item.is_last) begin
            if (!result.done_res && !was_drain) begin
                result.done_res   = 1'b1;
                result.end_reason = END_EOS;
            end
            nxt_state.phase      = PH_SKIP;
            nxt_state.unit_count = '0;
            nxt_state.high_digit = '0;
        end

        has_result = result.byte_valid || result.done_res;
    end

endmodule

// ===== rtl/url_form_value_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_form_value_decoder_unit
// Streaming decoder for form-URL-encoded values, one character per transaction.
// ----------------------------------------------------------------------------
// The unit takes one character per cycle unless a result waits on m_ready while
// the held character gives another. A character passes an input register, is
// decoded by a single combinational step against the decoder state, and its
// result (if any) lands in the result register. Characters that give no result
// (skipped spaces, first escape digits, drained input) are absorbed without a
// result transaction. The result register lets a new character be taken while
// a finished result still waits on m_ready. Write buffer_len through the cfg
// channel only while the unit is idle.
module url_form_value_decoder_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  ufd_pkg::ufd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ufd_pkg::ufd_out_t m_data
);
    import ufd_pkg::*;

    logic [15:0] buffer_len_reg;
    logic [15:0] limit;
    logic        in_valid_reg;
    ufd_in_t     in_data_reg;
    logic        out_valid_reg;
    ufd_out_t    out_data_reg;
    ufd_state_t  state_reg;
    ufd_state_t  state_next;
    ufd_out_t    step_result;
    logic        step_has_result;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign limit     = buffer_len_reg - 16'd1;

    // Hold the buffer length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_len_reg <= BUFFER_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            buffer_len_reg <= cfg_wdata;
        end
    end

    ufd_step u_step (
        .cur_state (state_reg),
        .item      (in_data_reg),
        .limit     (limit),
        .nxt_state (state_next),
        .result    (step_result),
        .has_result(step_has_result)
    );

    // Advance the held character when it gives no result or its result has somewhere to go
    assign advance = in_valid_reg && (!out_valid_reg || m_ready || !step_has_result);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_SKIP, high_digit: 4'd0, unit_count: 16'd0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_has_result) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A result transaction always carries a byte or an end of value
    a_result_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_valid || m_data.done_res))
        else $error("empty result transaction");

    // Unused fields stay zero
    a_fields_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.done_res || m_data.end_reason == END_AMP) &&
                     (m_data.byte_valid || m_data.out_byte == 8'd0)))
        else $error("result field set without its flag");

    // The last character of a string always leaves the decoder at a fresh value
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.is_last) |=>
            (state_reg.phase == PH_SKIP && state_reg.unit_count == 16'd0 &&
             state_reg.high_digit == 4'd0))
        else $error("state not cleared after end of string");

    // A held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("pending result lost");

endmodule

// ===== tb/url_form_value_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_form_value_decoder_checker
// Watches the character, result and configuration channels of the form-URL
// value decoder, predicts each decoded output from the characters accepted,
// and compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
module url_form_value_decoder_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ufd_pkg::ufd_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ufd_pkg::ufd_out_t m_data,
    output int                pending,
    output int                fail_total
);
    import ufd_pkg::*;

    // Decoder state as the checker tracks it
    ufd_phase_t  dec_phase;
    logic [3:0]  esc_high;
    logic [15:0] unit_cnt;
    logic [15:0] buf_len;

    // Outcome of the character being decoded
    logic [7:0]  nxt_byte;
    logic        nxt_valid;
    logic        nxt_done;
    ufd_reason_t nxt_reason;

    ufd_out_t    decoded_q[$];
    ufd_out_t    want;
    int          fail_cnt = 0;

    // Nibble value of an escape digit; letters fold onto their low three bits
    function automatic logic [7:0] escape_digit(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UPA) begin
            v = {5'd0, c[2:0]} + 8'd9;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

    task automatic end_value(input ufd_reason_t why);
        nxt_done   = 1'b1;
        nxt_reason = why;
    endtask

    task automatic clear_value();
        dec_phase = PH_SKIP;
        unit_cnt  = '0;
        esc_high  = '0;
    endtask

    // One plain-mode character: terminator, limit hit or a new decode unit
    task automatic plain_unit(input logic [7:0] c, input bit at_lim);
        if (c == CH_AMP) begin
            end_value(END_AMP);
        end else if (c == CH_EQ) begin
            end_value(END_EQ);
        end else if (at_lim) begin
            end_value(END_LIMIT);
            dec_phase = PH_DRAIN;
        end else begin
            unit_cnt  = unit_cnt + 16'd1;
            dec_phase = PH_PLAIN;
            if (c == CH_PLUS) begin
                nxt_byte  = CH_SPACE;
                nxt_valid = 1'b1;
            end else if (c == CH_PCT) begin
                dec_phase = PH_HEX1;
            end else if (c != CH_SPACE) begin
                nxt_byte  = c;
                nxt_valid = 1'b1;
            end
        end
    endtask

    // Advance the tracked state by one character
    task automatic decode_char(input ufd_in_t it);
        logic [15:0] lim;
        logic [7:0]  dv;
        bit          at_lim;
        bit          was_drain;
        lim       = buf_len - 16'd1;
        at_lim    = (unit_cnt >= lim);
        was_drain = (dec_phase == PH_DRAIN);
        dv        = escape_digit(it.ch);
        nxt_byte   = 8'h00;
        nxt_valid  = 1'b0;
        nxt_done   = 1'b0;
        nxt_reason = END_AMP;

        case (dec_phase)
            PH_PLAIN: begin
                plain_unit(it.ch, at_lim);
            end
            PH_HEX1: begin
                esc_high  = dv[3:0];
                dec_phase = PH_HEX2;
            end
            PH_HEX2: begin
                nxt_byte  = {esc_high, 4'd0} + dv;
                nxt_valid = 1'b1;
                dec_phase = PH_PLAIN;
            end
            PH_QUOTE: begin
                if (it.ch == CH_QUOTE) begin
                    dec_phase = PH_AFTQ;
                end else if (at_lim) begin
                    end_value(END_LIMIT);
                    dec_phase = PH_DRAIN;
                end else begin
                    nxt_byte  = it.ch;
                    nxt_valid = 1'b1;
                    unit_cnt  = unit_cnt + 16'd1;
                end
            end
            PH_AFTQ: begin
                if (it.ch == CH_AMP) begin
                    end_value(END_AMP);
                end else if (it.ch == CH_EQ) begin
                    end_value(END_EQ);
                end
            end
            PH_DRAIN: begin
                if (it.ch == CH_AMP || it.ch == CH_EQ) begin
                    clear_value();
                end
            end
            default: begin
                // leading skip, and the unused code that behaves like it
                if (it.ch == CH_SPACE || it.ch == CH_EQ) begin
                    dec_phase = PH_SKIP;
                end else if (it.ch == CH_QUOTE) begin
                    dec_phase = PH_QUOTE;
                end else begin
                    plain_unit(it.ch, at_lim);
                end
            end
        endcase

        if (nxt_done && nxt_reason != END_LIMIT) begin
            clear_value();
        end
        if (it.is_last) begin
            if (!nxt_done && !was_drain) begin
                end_value(END_EOS);
            end
            clear_value();
        end
    endtask

    // Track configuration, compare results, then predict the new character
    always @(posedge aclk) begin
        if (!aresetn) begin
            buf_len = BUFFER_LEN_RESET;
            clear_value();
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                buf_len = cfg_wdata;
            end

            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result transaction: 0x%03h", m_data);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.out_byte, m_data.out_byte);
                        fail_cnt++;
                    end
                    if (m_data.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b",
                               want.byte_valid, m_data.byte_valid);
                        fail_cnt++;
                    end
                    if (m_data.done_res !== want.done_res) begin
                        $error("done_res: expected %0b, actual %0b",
                               want.done_res, m_data.done_res);
                        fail_cnt++;
                    end
                    if (m_data.end_reason !== want.end_reason) begin
                        $error("end_reason: expected %0d, actual %0d",
                               want.end_reason, m_data.end_reason);
                        fail_cnt++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                decode_char(s_data);
                if (nxt_valid || nxt_done) begin
                    want.out_byte   = nxt_valid ? nxt_byte : 8'h00;
                    want.byte_valid = nxt_valid;
                    want.done_res   = nxt_done;
                    want.end_reason = nxt_done ? nxt_reason : END_AMP;
                    decoded_q.insert(decoded_q.size(), want);
                end
            end
        end
        pending    <= decoded_q.size();
        fail_total <= fail_cnt;
    end

endmodule

// ===== tb/tb_url_form_value_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_form_value_decoder_unit
// Drives the form-URL value decoder with a directed opening sequence and
// random form strings over several buffer lengths, with random gaps on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_url_form_value_decoder_unit;
    import ufd_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    ufd_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    ufd_out_t    m_data;

    int          pending;
    int          fail_total;
    int          chars_sent = 0;
    bit          tx_burst   = 1'b0;
    bit          rx_burst   = 1'b0;
    ufd_in_t     str_q[$];

    // Buffer lengths per random phase; the sixth is replaced at run time
    logic [15:0] len_plan [7] = '{16'd2, 16'd1, 16'd0, 16'hFFFF, 16'd5, 16'd8, 16'd256};

    url_form_value_decoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    url_form_value_decoder_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .pending    (pending),
        .fail_total (fail_total)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic ufd_in_t mk(input logic [7:0] c, input logic last);
        ufd_in_t it;
        it.ch      = c;
        it.is_last = last;
        return it;
    endfunction

    // Offer one character after a random gap and hold it until accepted
    task automatic send_char(input ufd_in_t d);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input bit last_flag);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_char(mk(txt[i], last_flag && (i == txt.len() - 1)));
        end
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic wait_decoder_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_buffer_len(input logic [15:0] v);
        wait_decoder_drained();
        // let characters that give no result clear the pipeline
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_char(input logic [7:0] c);
        str_q.insert(str_q.size(), mk(c, 1'b0));
    endtask

    function automatic logic [7:0] hex_char();
        string hx;
        hx = "0123456789ABCDEFabcdef";
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return hx[$urandom_range(0, 21)];
    endfunction

    // One plain-mode decode unit: letter, digit, plus, space, escape or any byte
    task automatic queue_plain_unit();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: queue_char(8'h61 + 8'($urandom_range(0, 25)));
            2, 3: queue_char(CH_ZERO + 8'($urandom_range(0, 9)));
            4:    queue_char(CH_PLUS);
            5:    queue_char(CH_SPACE);
            6, 7: begin
                queue_char(CH_PCT);
                queue_char(hex_char());
                queue_char(hex_char());
            end
            8:    queue_char(8'($urandom_range(0, 255)));
            default: queue_char(CH_UPA + 8'($urandom_range(0, 25)));
        endcase
    endtask

    // Build a form string of one to three values, mostly well formed
    task automatic build_form_string();
        int      n_vals;
        int      n;
        int      v;
        int      kind;
        str_q.delete();
        n_vals = $urandom_range(1, 3);
        for (v = 0; v < n_vals; v++) begin
            if (v > 0) begin
                queue_char($urandom_range(0, 1) ? CH_AMP : CH_EQ);
            end
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
                queue_char($urandom_range(0, 1) ? CH_SPACE : CH_EQ);
            end
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20)
                                                : $urandom_range(0, 5);
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                queue_char(CH_QUOTE);
                repeat (n) begin
                    if ($urandom_range(0, 5) == 0) begin
                        queue_char($urandom_range(0, 1) ? CH_AMP : CH_EQ);
                    end else begin
                        queue_char(8'($urandom_range(0, 255)));
                    end
                end
                // leave some quotes open to the end of the string
                if ($urandom_range(0, 3) != 0) begin
                    queue_char(CH_QUOTE);
                    repeat ($urandom_range(0, 2)) queue_char(8'($urandom_range(0, 255)));
                end
            end else if (kind < 9) begin
                repeat (n) queue_plain_unit();
            end else begin
                repeat (n) queue_char(8'($urandom_range(0, 255)));
            end
        end
        // cut an escape short at the end of the string now and then
        if ($urandom_range(0, 5) == 0) begin
            queue_char(CH_PCT);
        end
        if ($urandom_range(0, 5) == 0) begin
            queue_char($urandom_range(0, 1) ? CH_AMP : CH_EQ);
        end
        if (str_q.size() == 0) begin
            queue_char(CH_SPACE);
        end
        str_q[str_q.size() - 1].is_last = 1'b1;
    endtask

    // Result side: random stall before each transaction
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        int      p;
        int      phase_start;
        ufd_in_t it;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: skip, plus, dropped space, escapes with odd digits,
        // byte extremes, quoted terminators, text after the closing quote,
        // cut escape, skipped-only string and unclosed quote
        send_text(" =a+ %Ff", 1'b0);
        send_char(mk(CH_PCT, 1'b0));
        send_char(mk(CH_AMP, 1'b0));
        send_char(mk(8'hFF, 1'b0));
        send_char(mk(8'h00, 1'b0));
        send_char(mk(8'hFF, 1'b0));
        send_char(mk(CH_AMP, 1'b0));
        send_text("\"&=\"x=", 1'b0);
        send_text("%4", 1'b1);
        send_text(" ", 1'b1);
        send_text("\"q", 1'b1);

        // Random form strings, one buffer length per phase
        len_plan[5] = 16'($urandom_range(3, 12));
        for (p = 0; p < 7; p++) begin
            write_buffer_len(len_plan[p]);
            phase_start = chars_sent;
            while (chars_sent - phase_start < 64) begin
                if ($urandom_range(0, 59) == 0) begin
                    wait_decoder_drained();
                end
                build_form_string();
                while (str_q.size() > 0) begin
                    it = str_q.pop_front();
                    send_char(it);
                end
            end
        end

        wait_decoder_drained();
        repeat (8) @(posedge aclk);
        if (fail_total == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : run_limit
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== url_form_value_decoder_unit.f =====
rtl/ufd_pkg.sv
rtl/ufd_step.sv
rtl/url_form_value_decoder_unit.sv
tb/url_form_value_decoder_checker.sv
tb/tb_url_form_value_decoder_unit.sv
